// File: rtl/core/cdq_pkg.sv
`timescale 1ns / 1ps

package cdq_pkg;

  // Default capacity of the queue.
  localparam int unsigned DEPTH_DEF = 16;

  // Widths of the stream fields.
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;

  // Padded stream data widths.
  localparam int unsigned S_TDATA_W = ((CMD_W + DATA_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((DATA_W + STATUS_W + OCC_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_REAR  = 3'd5
  } cdq_cmd_e;

  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
    logic load_gather;
    logic shift_gather;
  } cdq_cell_op_t;

endpackage

// File: rtl/core/cdq_cell.sv
`timescale 1ns / 1ps

// One slot of the queue. Cells are ordered from the front; the occupied
// cells always form an unbroken run starting at the first cell.
module cdq_cell
  import cdq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cdq_cell_op_t      op_i,
  input  logic [DATA_W-1:0] push_value_i,
  input  logic [DATA_W-1:0] left_data_i,
  input  logic              left_valid_i,
  input  logic [DATA_W-1:0] right_data_i,
  input  logic              right_valid_i,
  input  logic [DATA_W-1:0] right_gather_i,
  output logic [DATA_W-1:0] data_o,
  output logic              valid_o,
  output logic [DATA_W-1:0] gather_o
);

  logic [DATA_W-1:0] data_q, data_d;
  logic [DATA_W-1:0] gather_q, gather_d;
  logic              valid_q, valid_d;
  logic              is_rear;

  // This cell holds the rear element when it is occupied and its right
  // neighbor is not.
  assign is_rear = valid_q && !right_valid_i;

  always_comb begin
    data_d   = data_q;
    valid_d  = valid_q;
    gather_d = gather_q;
    if (op_i.push_front) begin
      data_d  = left_data_i;
      valid_d = left_valid_i;
    end
    if (op_i.push_rear && !valid_q && left_valid_i) begin
      data_d  = push_value_i;
      valid_d = 1'b1;
    end
    if (op_i.pop_front) begin
      data_d  = right_data_i;
      valid_d = right_valid_i;
    end
    if (op_i.pop_rear && is_rear) begin
      valid_d = 1'b0;
    end
    if (op_i.load_gather) begin
      gather_d = is_rear ? data_q : '0;
    end
    if (op_i.shift_gather) begin
      gather_d = right_gather_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q   <= data_d;
    gather_q <= gather_d;
  end

  assign data_o   = data_q;
  assign valid_o  = valid_q;
  assign gather_o = gather_q;

endmodule

// File: rtl/core/circular_double_ended_queue.sv
`timescale 1ns / 1ps

// Fixed-capacity double-ended queue of signed 32-bit values, DEPTH entries.
// Each request on the slave stream carries one command: push front, push
// rear, pop front, pop rear, peek front or peek rear; every request yields
// exactly one response on the master stream with the peeked value (-1 on an
// empty-queue peek, 0 otherwise), a status (done, overflow when a push hits
// a full queue, underflow when a pop or peek finds the queue empty) and the
// element count after the command. The storage is a row of DEPTH cells that
// keeps the elements in order from the front: a push front shifts every
// cell one place toward the rear, a pop front shifts toward the front, and
// rear pushes and pops touch only the cell at the end of the occupied run.
// Every command but a peek at the rear of a non-empty queue is answered at
// once, so such commands are accepted back to back as long as the response
// is taken. Such a rear peek loads the rear value into a gather chain that
// hands it from cell to cell toward the front, one cell per cycle; no new
// request is accepted until its response is loaded. The response register
// can load a new response in the same cycle that its previous one is taken,
// so a waiting response holds off new requests only while it is not taken.
module circular_double_ended_queue
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Request stream. tdata: [2:0] command, [34:3] push_value, rest zero.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // Response stream. tdata: [31:0] read_value, [33:32] status,
  // [38:34] occupancy, rest zero.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Control states.
  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_GATHER = 1'b1;

  logic              state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  remain_q, remain_d;

  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] out_value_q, out_value_d;
  logic [STATUS_W-1:0]      out_status_q, out_status_d;
  logic [OCC_W-1:0]         out_occ_q, out_occ_d;

  logic                     accept;
  logic                     out_free;
  logic                     emit;
  cdq_cmd_e                 cmd;
  logic signed [DATA_W-1:0] push_value;
  logic                     empty;
  logic                     full;
  logic [CNT_W+OCC_W-1:0]   occ_wide;
  cdq_cell_op_t             op;

  logic [DATA_W-1:0] cell_data   [DEPTH];
  logic              cell_valid  [DEPTH];
  logic [DATA_W-1:0] cell_gather [DEPTH];

  assign cmd        = cdq_cmd_e'(s_axis_tdata[CMD_W-1:0]);
  assign push_value = s_axis_tdata[CMD_W +: DATA_W];

  // The output register is free when it is empty or is being drained now.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign empty = !cell_valid[0];
  assign full  = cell_valid[DEPTH-1];

  // The chain of cells, front first.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_data;
    logic              left_valid;
    logic [DATA_W-1:0] right_data;
    logic              right_valid;
    logic [DATA_W-1:0] right_gather;

    if (i == 0) begin : g_first
      // The front cell sees the pushed value as an always occupied left
      // neighbor, which makes it the landing spot of any push on an empty
      // queue.
      assign left_data  = push_value;
      assign left_valid = 1'b1;
    end else begin : g_inner_left
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data   = '0;
      assign right_valid  = 1'b0;
      assign right_gather = '0;
    end else begin : g_inner_right
      assign right_data   = cell_data[i+1];
      assign right_valid  = cell_valid[i+1];
      assign right_gather = cell_gather[i+1];
    end

    cdq_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .op_i           (op),
      .push_value_i   (push_value),
      .left_data_i    (left_data),
      .left_valid_i   (left_valid),
      .right_data_i   (right_data),
      .right_valid_i  (right_valid),
      .right_gather_i (right_gather),
      .data_o         (cell_data[i]),
      .valid_o        (cell_valid[i]),
      .gather_o       (cell_gather[i])
    );
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    remain_d     = remain_q;
    op           = '0;
    emit         = 1'b0;
    out_value_d  = '0;
    out_status_d = STATUS_DONE;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          emit = 1'b1;
          unique case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
              if (full) begin
                out_status_d = STATUS_OVERFLOW;
              end else begin
                op.push_front = (cmd == CMD_PUSH_FRONT);
                op.push_rear  = (cmd == CMD_PUSH_REAR);
                count_d       = count_q + CNT_W'(1);
              end
            end
            CMD_POP_FRONT, CMD_POP_REAR: begin
              if (empty) begin
                out_status_d = STATUS_UNDERFLOW;
              end else begin
                op.pop_front = (cmd == CMD_POP_FRONT);
                op.pop_rear  = (cmd == CMD_POP_REAR);
                count_d      = count_q - CNT_W'(1);
              end
            end
            CMD_PEEK_FRONT: begin
              if (empty) begin
                out_status_d = STATUS_UNDERFLOW;
                out_value_d  = '1;
              end else begin
                out_value_d  = cell_data[0];
              end
            end
            CMD_PEEK_REAR: begin
              if (empty) begin
                out_status_d = STATUS_UNDERFLOW;
                out_value_d  = '1;
              end else begin
                // Capture the rear value in its cell, then walk it forward.
                emit           = 1'b0;
                op.load_gather = 1'b1;
                remain_d       = count_q - CNT_W'(1);
                state_d        = ST_GATHER;
              end
            end
            default: begin
              // Unused command codes leave the queue untouched.
            end
          endcase
        end
      end
      ST_GATHER: begin
        if (remain_q != '0) begin
          op.shift_gather = 1'b1;
          remain_d        = remain_q - CNT_W'(1);
        end else if (out_free) begin
          emit        = 1'b1;
          out_value_d = cell_gather[0];
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The count is reported modulo 2**OCC_W, the range of the occupancy field.
  assign occ_wide  = {{OCC_W{1'b0}}, count_d};
  assign out_occ_d = occ_wide[OCC_W-1:0];

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
      out_occ_q    <= out_occ_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W - DATA_W - STATUS_W - OCC_W){1'b0}},
                          out_occ_q, out_status_q, out_value_q};

endmodule

// File: sim/cdq_checker.sv
`timescale 1ns / 1ps

// Watches both streams of the deque, keeps its own copy of the queue state
// and compares every response with the answer predicted for its request.
module cdq_checker
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [M_TDATA_W-1:0] m_axis_tdata,
  output int                   fail_count_o,
  output int                   pending_o
);

  // Same layout as the response tdata: read_value in the lowest bits.
  typedef struct packed {
    logic [OCC_W-1:0]    occupancy;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   read_value;
  } answer_t;

  logic [DATA_W-1:0] shadow_store [DEPTH];
  int unsigned       front_idx;
  int unsigned       rear_idx;
  int unsigned       held;
  answer_t           answers_due [$];
  int                fails;

  // Applies one command to the shadow deque and returns the response it owes.
  function automatic answer_t apply_command(logic [CMD_W-1:0] cmd,
                                            logic [DATA_W-1:0] value);
    answer_t ans;
    ans = '0;
    ans.status = STATUS_DONE;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (held >= DEPTH) begin
          ans.status = STATUS_OVERFLOW;
        end else if (held == 0) begin
          front_idx       = 0;
          rear_idx        = 0;
          shadow_store[0] = value;
          held            = 1;
        end else if (cmd == CMD_PUSH_FRONT) begin
          front_idx = (front_idx == 0) ? DEPTH - 1 : front_idx - 1;
          shadow_store[front_idx] = value;
          held++;
        end else begin
          rear_idx = (rear_idx == DEPTH - 1) ? 0 : rear_idx + 1;
          shadow_store[rear_idx] = value;
          held++;
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR: begin
        if (held == 0) begin
          ans.status = STATUS_UNDERFLOW;
        end else if (held == 1) begin
          front_idx = 0;
          rear_idx  = 0;
          held      = 0;
        end else begin
          if (cmd == CMD_POP_FRONT) begin
            front_idx = (front_idx == DEPTH - 1) ? 0 : front_idx + 1;
          end else begin
            rear_idx = (rear_idx == 0) ? DEPTH - 1 : rear_idx - 1;
          end
          held--;
        end
      end
      CMD_PEEK_FRONT, CMD_PEEK_REAR: begin
        if (held == 0) begin
          ans.status     = STATUS_UNDERFLOW;
          ans.read_value = '1;
        end else begin
          ans.read_value = shadow_store[(cmd == CMD_PEEK_FRONT) ? front_idx : rear_idx];
        end
      end
      default: begin
        // Spare command codes leave the deque alone.
      end
    endcase
    ans.occupancy = OCC_W'(held);
    return ans;
  endfunction

  always @(posedge clk_i) begin
    answer_t got;
    answer_t want;
    if (!rst_ni) begin
      front_idx = 0;
      rear_idx  = 0;
      held      = 0;
      fails     = 0;
      answers_due.delete();
    end else begin
      // Requests are taken first so that a same-edge response would still match.
      if (s_axis_tvalid && s_axis_tready) begin
        answers_due.push_back(apply_command(s_axis_tdata[CMD_W-1:0],
                                            s_axis_tdata[CMD_W +: DATA_W]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = answer_t'(m_axis_tdata[$bits(answer_t)-1:0]);
        if (answers_due.size() == 0) begin
          $display("%0t: response %h arrived with no request outstanding", $time, got);
          fails++;
        end else begin
          want = answers_due.pop_front();
          if (got.read_value !== want.read_value) begin
            $display("%0t: read_value expected %h actual %h",
                     $time, want.read_value, got.read_value);
            fails++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            fails++;
          end
          if (got.occupancy !== want.occupancy) begin
            $display("%0t: occupancy expected %0d actual %0d",
                     $time, want.occupancy, got.occupancy);
            fails++;
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= answers_due.size();
  end

endmodule

// File: sim/circular_double_ended_queue_tb.sv
`timescale 1ns / 1ps

// Drives command requests into the deque and lets the response stream stall
// on its own pattern. All prediction and comparison lives in the checker;
// this module only makes traffic and gives the verdict.
module circular_double_ended_queue_tb;
  import cdq_pkg::*;

  // Command codes the deque does not define; it must ignore them.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  localparam int RANDOM_REQUESTS = 1250;
  localparam int LONG_HOLD       = 300;
  localparam int HOLD_AFTER      = 300;
  localparam int DRAIN_CYCLES    = 40;
  localparam int CYCLE_LIMIT     = 400000;

  // Biases that steer the random traffic toward full, toward empty, or neither.
  localparam int BIAS_FILL  = 0;
  localparam int BIAS_DRAIN = 1;
  localparam int BIAS_MIXED = 2;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  int fail_count;
  int answers_pending;
  int requests_sent = 0;
  int cycle_count   = 0;

  circular_double_ended_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  cdq_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (answers_pending)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Hard stop in case the deque wedges or a response never comes.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Holds one request on the bus until the deque takes it. Returns at the
  // following falling edge with tvalid still high, so the caller either
  // offers the next request there or drops tvalid for a gap.
  task automatic offer(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W - CMD_W - DATA_W){1'b0}}, value, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // Push values lean on the sign extremes, all ones and zero.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '1;
      3:       return '0;
      default: return $urandom();
    endcase
  endfunction

  // Picks a command under the current bias. Pushes dominate while filling so
  // the queue reaches full and overflows; pops dominate while draining so it
  // empties and underflows. Peeks and a trickle of spare codes stay in all.
  function automatic logic [CMD_W-1:0] pick_command(int bias);
    int roll;
    int push_pct;
    int pop_pct;
    roll     = $urandom_range(0, 99);
    push_pct = (bias == BIAS_FILL) ? 62 : (bias == BIAS_DRAIN) ? 15 : 38;
    pop_pct  = (bias == BIAS_FILL) ? 15 : (bias == BIAS_DRAIN) ? 62 : 38;
    if (roll < push_pct) begin
      return $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
    end else if (roll < push_pct + pop_pct) begin
      return $urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT;
    end else if (roll < 98) begin
      return $urandom_range(0, 1) ? CMD_PEEK_REAR : CMD_PEEK_FRONT;
    end else begin
      return $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
    end
  endfunction

  // Response side. It stalls on a pattern that changes mode now and then,
  // including long always-ready stretches. Once, after a few hundred
  // requests, it holds off long enough for the deque to back up and refuse
  // requests while the sender keeps offering.
  initial begin
    int  stall_mode;
    int  mode_left;
    bit  long_hold_done;
    stall_mode     = 0;
    mode_left      = 0;
    long_hold_done = 1'b0;
    m_axis_tready  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && requests_sent >= HOLD_AFTER) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        long_hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(16, 96);
      end
      mode_left--;
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        2:       m_axis_tready <= $urandom_range(0, 1);
        default: m_axis_tready <= ((mode_left % 5) < 3);
      endcase
    end
  end

  // Request side: a short directed opening, then biased random bursts.
  initial begin
    int burst_left;
    int gap;
    int bias;
    int bias_left;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Every pop and peek on the empty deque underflows; peeks answer all ones.
    offer(CMD_PEEK_FRONT, '0);
    offer(CMD_PEEK_REAR, '0);
    offer(CMD_POP_FRONT, '0);
    offer(CMD_POP_REAR, '0);
    offer(CMD_SPARE_LO, '1);
    // The first push into an empty deque lands in the first slot from either
    // end. Then fill to capacity from both ends, wrapping the front index.
    offer(CMD_PUSH_FRONT, 32'h7fff_ffff);
    offer(CMD_PUSH_REAR, 32'h8000_0000);
    offer(CMD_PUSH_FRONT, '1);
    for (int k = 0; k < DEPTH_DEF - 3; k++) begin
      offer((k % 2) ? CMD_PUSH_REAR : CMD_PUSH_FRONT, (k == 0) ? '0 : $urandom());
    end
    // Pushes into the full deque are refused at both ends.
    offer(CMD_PUSH_FRONT, 32'h1234_5678);
    offer(CMD_PUSH_REAR, 32'h8765_4321);
    offer(CMD_PEEK_FRONT, '0);
    offer(CMD_PEEK_REAR, '0);
    offer(CMD_SPARE_HI, '1);

    // Random traffic in bursts of random length with random gaps. The bias
    // switches now and then so the deque swings between full and empty,
    // which also exercises popping the last element from either end.
    burst_left = 0;
    bias       = BIAS_FILL;
    bias_left  = 0;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (bias_left == 0) begin
        bias      = $urandom_range(BIAS_FILL, BIAS_MIXED);
        bias_left = $urandom_range(20, 80);
      end
      bias_left--;
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      offer(pick_command(bias), pick_value());
    end
    s_axis_tvalid <= 1'b0;

    // Let every outstanding response arrive, then allow a slow rear peek's
    // worth of extra cycles so a stray response would still be caught.
    do @(posedge clk_i); while (answers_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
